[sv/tccr_pkg.sv]
// Shared constants, types and the CRC byte update for the telecommand report block.
package tccr_pkg;

  localparam int unsigned ApidW  = 11;
  localparam int unsigned DestW  = 8;
  localparam int unsigned CountW = 14;
  localparam int unsigned PosW   = 17;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned AddrW  = 3;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [ApidW-1:0] ApidReset = 11'd812;
  localparam logic [DestW-1:0] DestReset = 8'h78;

  // Telecommand layout: ten bytes of headers ahead of the application data,
  // whose byte count is the length field minus five.
  localparam logic [PosW-1:0] HdrBytes = 17'd10;
  localparam logic [15:0]     LenBias  = 16'd5;

  // Report fields.
  localparam logic [15:0] LenAccept = 16'h0007;
  localparam logic [15:0] LenReject = 16'h000D;
  localparam logic [15:0] ErrCrc    = 16'h0002;
  localparam logic [7:0]  SvcType   = 8'h01;
  localparam logic [7:0]  SecHdr    = 8'h10;
  localparam logic [7:0]  SubAccept = 8'h01;
  localparam logic [7:0]  SubReject = 8'h02;
  localparam logic [4:0]  PidHigh   = 5'b00001;
  localparam logic [1:0]  SeqFlags  = 2'b11;

  // Byte index of the final byte of each report kind.
  localparam logic [IdxW-1:0] LastAccept = 5'd13;
  localparam logic [IdxW-1:0] LastReject = 5'd19;

  // Register map index (byte address / 4).
  typedef enum logic {
    RegApid = 1'b0,
    RegDest = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ApidW-1:0] apid;
    logic [DestW-1:0] dest;
  } cfg_t;

  typedef struct packed {
    logic              accepted;
    logic [CountW-1:0] count;
    logic [15:0]       pid;
    logic [15:0]       seq;
    logic [15:0]       rx_crc;
    logic [15:0]       calc_crc;
  } report_t;

  // CRC-16-CCITT, MSB first, one byte per call.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[sv/telecommand_crc_check_and_report_core.sv]
// Throughput: one telecommand byte per cycle while tc_ready_o is high; reports leave through
// the output register one byte per cycle while tm_ready_i is high, 14 or 20 bytes each.
// Input stalls only while a finished report waits behind the one being sent (one pending slot).
// Reset: asynchronous and active low; packet position, CRC (0xFFFF), report count and
// all valid flags clear, and the registers return to APID 812 and destination 120.
// Top level of the telecommand CRC check and verification report block.
module telecommand_crc_check_and_report_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Telecommand byte stream.
  input  logic                       tc_valid_i,
  output logic                       tc_ready_o,
  input  logic [7:0]                 tc_byte_i,
  // Verification report byte stream.
  output logic                       tm_valid_o,
  input  logic                       tm_ready_i,
  output logic [7:0]                 tm_byte_o,
  output logic                       tm_last_o,
  output logic                       accepted_o,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tccr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  tccr_pkg::cfg_t    cfg;
  tccr_pkg::report_t rep;
  logic              rep_valid;
  logic              take;

  // A byte transaction completes when valid and ready meet; the parser
  // updates its header fields and CRC in that same cycle.
  assign take = tc_valid_i && tc_ready_o;

  // Register file: APID at byte address 0, destination at byte address 4.
  tccr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The parser raises rep_valid on the last byte of a packet, with a full
  // snapshot of the IDs, both CRC values, the verdict and the report count.
  tccr_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (tc_byte_i),
    .rep_valid_o (rep_valid),
    .rep_o       (rep)
  );

  // The serializer holds one report in flight and one pending. The input
  // side is held off only while the pending slot is occupied, so the
  // shortest packets (12 bytes) can still follow each other with no gap
  // until reports start to queue.
  tccr_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .rep_valid_i (rep_valid),
    .rep_i       (rep),
    .in_ready_o  (tc_ready_o),
    .tm_valid_o  (tm_valid_o),
    .tm_ready_i  (tm_ready_i),
    .tm_byte_o   (tm_byte_o),
    .tm_last_o   (tm_last_o),
    .accepted_o  (accepted_o)
  );

endmodule

[sv/tccr_cfg.sv]
// APB configuration registers for the report APID and destination.
module tccr_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tccr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tccr_pkg::cfg_t             cfg_o
);

  logic [tccr_pkg::ApidW-1:0] apid_q, apid_d;
  logic [tccr_pkg::DestW-1:0] dest_q, dest_d;
  tccr_pkg::reg_idx_e         idx;
  logic                       wr_en;

  assign pready = 1'b1;
  assign idx    = tccr_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    apid_d = apid_q;
    dest_d = dest_q;
    prdata = '0;
    unique case (idx)
      tccr_pkg::RegApid: begin
        prdata = {21'd0, apid_q};
        if (wr_en) begin
          apid_d = pwdata[tccr_pkg::ApidW-1:0];
        end
      end
      tccr_pkg::RegDest: begin
        prdata = {24'd0, dest_q};
        if (wr_en) begin
          dest_d = pwdata[tccr_pkg::DestW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apid_q <= tccr_pkg::ApidReset;
      dest_q <= tccr_pkg::DestReset;
    end else begin
      apid_q <= apid_d;
      dest_q <= dest_d;
    end
  end

  assign cfg_o.apid = apid_q;
  assign cfg_o.dest = dest_q;

endmodule

[sv/tccr_rx.sv]
// Telecommand byte parser: header capture, running CRC and end-of-packet compare.
module tccr_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output logic              rep_valid_o,
  output tccr_pkg::report_t rep_o
);

  logic [tccr_pkg::PosW-1:0]   pos_q, pos_d;
  logic [15:0]                 pid_q, pid_d;
  logic [15:0]                 seq_q, seq_d;
  logic [15:0]                 len_q, len_d;
  logic [15:0]                 crc_q, crc_d;
  logic [7:0]                  rxhi_q, rxhi_d;
  logic [tccr_pkg::CountW-1:0] count_q, count_d;
  logic [15:0]                 data_cnt;
  logic [tccr_pkg::PosW-1:0]   crc_end;
  logic [15:0]                 rx_crc;

  // Before the length is complete, crc_end is at least ten, so the first
  // six bytes always land in the CRC branch.
  assign data_cnt = (len_q >= tccr_pkg::LenBias) ? (len_q - tccr_pkg::LenBias) : 16'd0;
  assign crc_end  = tccr_pkg::HdrBytes + {1'b0, data_cnt};
  assign rx_crc   = {rxhi_q, byte_i};

  always_comb begin
    pos_d       = pos_q;
    pid_d       = pid_q;
    seq_d       = seq_q;
    len_d       = len_q;
    crc_d       = crc_q;
    rxhi_d      = rxhi_q;
    count_d     = count_q;
    rep_valid_o = 1'b0;
    if (take_i) begin
      unique case (pos_q)
        17'd0:   pid_d[15:8] = byte_i;
        17'd1:   pid_d[7:0]  = byte_i;
        17'd2:   seq_d[15:8] = byte_i;
        17'd3:   seq_d[7:0]  = byte_i;
        17'd4:   len_d[15:8] = byte_i;
        17'd5:   len_d[7:0]  = byte_i;
        default: ;
      endcase
      priority if (pos_q < crc_end) begin
        crc_d = tccr_pkg::crc_byte(crc_q, byte_i);
        pos_d = pos_q + 17'd1;
      end else if (pos_q == crc_end) begin
        rxhi_d = byte_i;
        pos_d  = pos_q + 17'd1;
      end else begin
        rep_valid_o = 1'b1;
        count_d     = count_q + 14'd1;
        pos_d       = '0;
        crc_d       = tccr_pkg::CrcInit;
      end
    end
  end

  assign rep_o.accepted = (rx_crc == crc_q);
  assign rep_o.count    = count_q;
  assign rep_o.pid      = pid_q;
  assign rep_o.seq      = seq_q;
  assign rep_o.rx_crc   = rx_crc;
  assign rep_o.calc_crc = crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pid_q   <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      crc_q   <= tccr_pkg::CrcInit;
      rxhi_q  <= '0;
      count_q <= '0;
    end else begin
      pos_q   <= pos_d;
      pid_q   <= pid_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rxhi_q  <= rxhi_d;
      count_q <= count_d;
    end
  end

endmodule

[sv/tccr_tx.sv]
// Report serializer: one pending slot, the report in flight and the output register.
module tccr_tx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tccr_pkg::cfg_t    cfg_i,
  input  logic              rep_valid_i,
  input  tccr_pkg::report_t rep_i,
  output logic              in_ready_o,
  output logic              tm_valid_o,
  input  logic              tm_ready_i,
  output logic [7:0]        tm_byte_o,
  output logic              tm_last_o,
  output logic              accepted_o
);

  logic                          pend_valid_q, pend_valid_d;
  tccr_pkg::report_t             pend_q, pend_d;
  logic                          cur_valid_q, cur_valid_d;
  tccr_pkg::report_t             cur_q, cur_d;
  logic [tccr_pkg::IdxW-1:0]     idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_byte_q, out_byte_d;
  logic                          out_last_q, out_last_d;
  logic                          out_acc_q, out_acc_d;
  logic                          out_load;
  logic                          cur_last;
  logic                          cur_free;
  logic [7:0]                    sel_byte;

  assign out_load = cur_valid_q && (!out_valid_q || tm_ready_i);
  assign cur_last = cur_q.accepted ? (idx_q == tccr_pkg::LastAccept)
                                   : (idx_q == tccr_pkg::LastReject);
  assign cur_free = !cur_valid_q || (out_load && cur_last);

  // Report byte at the current index.
  always_comb begin
    unique case (idx_q)
      5'd0:    sel_byte = {tccr_pkg::PidHigh, cfg_i.apid[10:8]};
      5'd1:    sel_byte = cfg_i.apid[7:0];
      5'd2:    sel_byte = {tccr_pkg::SeqFlags, cur_q.count[13:8]};
      5'd3:    sel_byte = cur_q.count[7:0];
      5'd4:    sel_byte = cur_q.accepted ? tccr_pkg::LenAccept[15:8]
                                         : tccr_pkg::LenReject[15:8];
      5'd5:    sel_byte = cur_q.accepted ? tccr_pkg::LenAccept[7:0]
                                         : tccr_pkg::LenReject[7:0];
      5'd6:    sel_byte = tccr_pkg::SecHdr;
      5'd7:    sel_byte = tccr_pkg::SvcType;
      5'd8:    sel_byte = cur_q.accepted ? tccr_pkg::SubAccept : tccr_pkg::SubReject;
      5'd9:    sel_byte = cfg_i.dest;
      5'd10:   sel_byte = cur_q.pid[15:8];
      5'd11:   sel_byte = cur_q.pid[7:0];
      5'd12:   sel_byte = cur_q.seq[15:8];
      5'd13:   sel_byte = cur_q.seq[7:0];
      5'd14:   sel_byte = tccr_pkg::ErrCrc[15:8];
      5'd15:   sel_byte = tccr_pkg::ErrCrc[7:0];
      5'd16:   sel_byte = cur_q.rx_crc[15:8];
      5'd17:   sel_byte = cur_q.rx_crc[7:0];
      5'd18:   sel_byte = cur_q.calc_crc[15:8];
      5'd19:   sel_byte = cur_q.calc_crc[7:0];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_acc_d    = out_acc_q;

    if (out_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_last_d  = cur_last;
      out_acc_d   = cur_q.accepted;
      idx_d       = cur_last ? '0 : idx_q + 5'd1;
    end else if (tm_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cur_free) begin
      if (pend_valid_q) begin
        cur_valid_d = 1'b1;
        cur_d       = pend_q;
      end else if (rep_valid_i) begin
        cur_valid_d = 1'b1;
        cur_d       = rep_i;
      end else begin
        cur_valid_d = 1'b0;
      end
    end

    // A new report only arrives while the pending slot is empty. It goes
    // straight to the serializer when that is free, else it waits here.
    if (rep_valid_i && !cur_free) begin
      pend_valid_d = 1'b1;
      pend_d       = rep_i;
    end else if (cur_free) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      cur_valid_q  <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      cur_valid_q  <= cur_valid_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_acc_q  <= out_acc_d;
  end

  assign in_ready_o = !pend_valid_q;
  assign tm_valid_o = out_valid_q;
  assign tm_byte_o  = out_byte_q;
  assign tm_last_o  = out_last_q;
  assign accepted_o = out_acc_q;

endmodule
